// ===== hdl/nsts_pkg.sv =====
// ----------------------------------------------------------------------------
// Note string tone sequencer package
// Shared types, constants and the note length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package nsts_pkg;

    localparam int ALU_W   = 27;
    localparam int ACC_W   = 26;
    localparam int K_W     = 10;
    localparam int QUO_W   = 16;
    localparam int DUR_W   = 20;
    localparam int GAP_W   = 10;
    localparam int SIZE_W  = 5;
    localparam int SCENE_W = 4;
    localparam int CNT_W   = 4;

    localparam logic [QUO_W-1:0] QUARTER_DIVIDEND = 16'd60000;

    localparam logic [1:0] EVENT_NOTE = 2'd0;
    localparam logic [1:0] EVENT_REST = 2'd1;
    localparam logic [1:0] EVENT_END  = 2'd2;

    localparam logic [6:0] INTENSITY_ACCENT = 7'd127;
    localparam logic [6:0] INTENSITY_NORMAL = 7'd40;

    localparam logic [1:0] CFG_TEMPO = 2'd0;
    localparam logic [1:0] CFG_GAP   = 2'd1;
    localparam logic [1:0] CFG_SHOW  = 2'd2;

    localparam logic [15:0]       TEMPO_RESET = 16'd120;
    localparam logic [GAP_W-1:0]  GAP_RESET   = 10'd20;
    localparam logic [SIZE_W-1:0] SHOW_RESET  = 5'd0;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_REST    = 8'h72;
    localparam logic [7:0] CHAR_ACCENT  = 8'h3E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_S       = 8'h73;
    localparam logic [7:0] CHAR_E       = 8'h65;
    localparam logic [7:0] CHAR_H       = 8'h68;
    localparam logic [7:0] CHAR_W       = 8'h77;

    localparam logic [5:0] EIGHTHS_QUARTER = 6'd8;

    typedef struct packed {
        logic           note;
        logic           rest;
        logic           accent;
        logic           tail_end;
        logic [K_W-1:0] k;
    } job_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DUR_W-1:0]   duration;
        logic [DUR_W-1:0]   buzz;
        logic [6:0]         intensity;
        logic               scene_valid;
        logic [SCENE_W-1:0] scene_index;
        logic               lights_half;
        logic               last;
    } result_t;

    function automatic logic [5:0] eighths_of(input logic [7:0] c);
        logic       upper;
        logic [7:0] lower;
        logic [5:0] e;
        upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
        lower = upper ? c + CASE_OFFSET : c;
        unique case (lower)
            CHAR_S:  e = 6'd2;
            CHAR_E:  e = 6'd4;
            CHAR_H:  e = 6'd16;
            CHAR_W:  e = 6'd32;
            default: e = EIGHTHS_QUARTER;
        endcase
        if (upper)
        begin
            e = e + (e >> 1);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nsts_alu.sv =====
// ----------------------------------------------------------------------------
// Shared adder and subtractor
// The one arithmetic unit used by the divide, multiply, gap and modulo steps.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_alu (
    input  wire logic [nsts_pkg::ALU_W-1:0] a,
    input  wire logic [nsts_pkg::ALU_W-1:0] b,
    input  wire logic                       sub,
    output logic      [nsts_pkg::ALU_W-1:0] sum,
    output logic                            neg
);

    always_comb
    begin
        sum = sub ? (a - b) : (a + b);
        neg = sum[nsts_pkg::ALU_W-1];
    end

endmodule

`default_nettype wire

// ===== hdl/nsts_parser.sv =====
// ----------------------------------------------------------------------------
// Music string parser
// Tracks prefix and multiplier state and issues note and end jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     symbol,
    input  wire logic           song_end,
    output nsts_pkg::job_t      job,
    output logic                job_start
);

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_MULT   = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       rest_reg;
    logic       rest_next;
    logic       accent_reg;
    logic       accent_next;
    logic [3:0] mult_reg;
    logic [3:0] mult_next;

    logic [1:0]                 phase_eff;
    logic                       digit;
    logic [7:0]                 digit_val;
    logic [5:0]                 eighths;
    logic [nsts_pkg::K_W-1:0]   k_full;

    always_comb
    begin
        phase_eff = ((phase_reg == PH_PREFIX) || (phase_reg == PH_MULT)) ? phase_reg : PH_START;
        digit     = (symbol >= nsts_pkg::CHAR_ZERO) && (symbol <= nsts_pkg::CHAR_NINE);
        digit_val = symbol - nsts_pkg::CHAR_ZERO;
        eighths   = song_end ? nsts_pkg::EIGHTHS_QUARTER : nsts_pkg::eighths_of(symbol);
        k_full    = {4'b0, eighths} * {6'b0, mult_reg};

        phase_next  = phase_reg;
        rest_next   = rest_reg;
        accent_next = accent_reg;
        mult_next   = mult_reg;
        job_start   = 1'b0;

        job.note     = 1'b1;
        job.rest     = rest_reg;
        job.accent   = accent_reg;
        job.tail_end = song_end;
        job.k        = k_full;

        if (accept)
        begin
            priority if (song_end)
            begin
                job_start   = 1'b1;
                job.note    = (phase_eff != PH_START);
                phase_next  = PH_START;
                rest_next   = 1'b0;
                accent_next = 1'b0;
                mult_next   = 4'd1;
            end
            else if ((phase_eff == PH_START) && (symbol == nsts_pkg::CHAR_SPACE))
            begin
                phase_next = phase_reg;
            end
            else if ((phase_eff == PH_START) && (symbol == nsts_pkg::CHAR_REST))
            begin
                rest_next  = 1'b1;
                phase_next = PH_PREFIX;
            end
            else if ((phase_eff == PH_START) && (symbol == nsts_pkg::CHAR_ACCENT))
            begin
                accent_next = 1'b1;
                phase_next  = PH_PREFIX;
            end
            else if ((phase_eff != PH_MULT) && digit)
            begin
                mult_next  = digit_val[3:0];
                phase_next = PH_MULT;
            end
            else
            begin
                job_start   = 1'b1;
                phase_next  = PH_START;
                rest_next   = 1'b0;
                accent_next = 1'b0;
                mult_next   = 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            rest_reg   <= 1'b0;
            accent_reg <= 1'b0;
            mult_reg   <= 4'd1;
        end
        else
        begin
            phase_reg  <= phase_next;
            rest_reg   <= rest_next;
            accent_reg <= accent_next;
            mult_reg   <= mult_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nsts_engine.sv =====
// ----------------------------------------------------------------------------
// Note timing engine
// Sequences the shared adder through divide, multiply, gap and scene steps
// and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_start,
    input  wire nsts_pkg::job_t                 job,
    input  wire logic [15:0]                    tempo,
    input  wire logic [nsts_pkg::GAP_W-1:0]     gap,
    input  wire logic [nsts_pkg::SIZE_W-1:0]    show_size,
    output logic                                busy,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output nsts_pkg::result_t                   result
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV      = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_BUZZ     = 3'd3;
    localparam logic [2:0] S_MOD      = 3'd4;
    localparam logic [2:0] S_NOTE_OUT = 3'd5;
    localparam logic [2:0] S_END_OUT  = 3'd6;

    localparam int ALU_W  = nsts_pkg::ALU_W;
    localparam int ACC_W  = nsts_pkg::ACC_W;
    localparam int QUO_W  = nsts_pkg::QUO_W;
    localparam int DUR_W  = nsts_pkg::DUR_W;
    localparam int CNT_W  = nsts_pkg::CNT_W;
    localparam int SIZE_W = nsts_pkg::SIZE_W;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [QUO_W-1:0]               rem_reg;
    logic [QUO_W-1:0]               rem_next;
    logic [QUO_W-1:0]               quo_reg;
    logic [QUO_W-1:0]               quo_next;
    logic [ACC_W-1:0]               acc_reg;
    logic [ACC_W-1:0]               acc_next;
    logic [ACC_W-1:0]               mcand_reg;
    logic [ACC_W-1:0]               mcand_next;
    logic [nsts_pkg::K_W-1:0]       mplier_reg;
    logic [nsts_pkg::K_W-1:0]       mplier_next;
    logic [DUR_W-1:0]               buzz_reg;
    logic [DUR_W-1:0]               buzz_next;
    logic [SIZE_W-1:0]              sval_reg;
    logic [SIZE_W-1:0]              sval_next;
    logic [nsts_pkg::SCENE_W-1:0]   scene_reg;
    logic [nsts_pkg::SCENE_W-1:0]   scene_next;
    logic                           hit_reg;
    logic                           hit_next;
    nsts_pkg::job_t                 job_reg;
    nsts_pkg::job_t                 job_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    nsts_pkg::result_t              result_reg;
    nsts_pkg::result_t              result_next;

    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic               alu_sub;
    logic [ALU_W-1:0]   alu_sum;
    logic               alu_neg;
    logic [QUO_W:0]     trial;
    logic [15:0]        tempo_eff;
    logic               out_free;

    nsts_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .neg (alu_neg)
    );

    always_comb
    begin
        tempo_eff = (tempo == 16'd0) ? 16'd1 : tempo;
        trial     = {rem_reg, nsts_pkg::QUARTER_DIVIDEND[cnt_reg]};
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        unique case (state_reg)
            S_DIV:
            begin
                alu_a   = {{(ALU_W-QUO_W-1){1'b0}}, trial};
                alu_b   = {{(ALU_W-16){1'b0}}, tempo_eff};
                alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_a = {{(ALU_W-ACC_W){1'b0}}, acc_reg};
                alu_b = {{(ALU_W-ACC_W){1'b0}}, mcand_reg};
            end
            S_BUZZ:
            begin
                alu_a   = {{(ALU_W-ACC_W+3){1'b0}}, acc_reg[ACC_W-1:3]};
                alu_b   = {{(ALU_W-nsts_pkg::GAP_W){1'b0}}, gap};
                alu_sub = 1'b1;
            end
            S_MOD:
            begin
                alu_a   = {{(ALU_W-SIZE_W){1'b0}}, sval_reg};
                alu_b   = {{(ALU_W-SIZE_W){1'b0}}, show_size};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        buzz_next      = buzz_reg;
        sval_next      = sval_reg;
        scene_next     = scene_reg;
        hit_next       = hit_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_start)
                begin
                    job_next   = job;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '1;
                    state_next = job.note ? S_DIV : S_END_OUT;
                end
            end
            S_DIV:
            begin
                rem_next = alu_neg ? trial[QUO_W-1:0] : alu_sum[QUO_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], !alu_neg};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next    = '0;
                    mcand_next  = {{(ACC_W-QUO_W){1'b0}}, quo_next};
                    mplier_next = job_reg.k;
                    cnt_next    = CNT_W'(nsts_pkg::K_W - 1);
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_sum[ACC_W-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_BUZZ;
                end
            end
            S_BUZZ:
            begin
                buzz_next  = alu_neg ? '0 : alu_sum[DUR_W-1:0];
                sval_next  = {1'b0, scene_reg} + 1'b1;
                hit_next   = !job_reg.rest && (show_size != '0);
                state_next = (!job_reg.rest && (show_size != '0)) ? S_MOD : S_NOTE_OUT;
            end
            S_MOD:
            begin
                if (alu_neg)
                begin
                    scene_next = sval_reg[nsts_pkg::SCENE_W-1:0];
                    state_next = S_NOTE_OUT;
                end
                else
                begin
                    sval_next = alu_sum[SIZE_W-1:0];
                end
            end
            S_NOTE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    result_next.kind        = job_reg.rest ? nsts_pkg::EVENT_REST
                                                           : nsts_pkg::EVENT_NOTE;
                    result_next.duration    = acc_reg[DUR_W+2:3];
                    result_next.buzz        = job_reg.rest ? '0 : buzz_reg;
                    result_next.intensity   = job_reg.rest   ? 7'd0 :
                                              job_reg.accent ? nsts_pkg::INTENSITY_ACCENT
                                                             : nsts_pkg::INTENSITY_NORMAL;
                    result_next.scene_valid = hit_reg;
                    result_next.scene_index = hit_reg ? scene_reg : '0;
                    result_next.lights_half = !job_reg.rest && job_reg.accent;
                    result_next.last        = !job_reg.tail_end;
                    state_next              = job_reg.tail_end ? S_END_OUT : S_IDLE;
                end
            end
            S_END_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    result_next.kind = nsts_pkg::EVENT_END;
                    result_next.last = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            scene_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scene_reg     <= scene_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        buzz_reg   <= buzz_next;
        sval_reg   <= sval_next;
        hit_reg    <= hit_next;
        job_reg    <= job_next;
        result_reg <= result_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== hdl/note_string_tone_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Note string tone sequencer
// Turns a music string, one character per transfer, into tone events.
// ----------------------------------------------------------------------------
// A space or prefix at the start of a note, or its first digit, is taken
// without an event. A note letter keeps the input stalled through a 16-step
// divide of 60000 by the tempo, a 10-step shift-and-add multiply by the note
// length, one gap subtraction and, when a light scene is stepped, a
// repeated-subtraction scene modulo, all on one shared adder/subtractor. A
// song end also produces the all-off event. The finished event waits in
// an output register, so the next character can be taken while it is stalled.
`default_nettype none

module note_string_tone_sequencer_top #(
    parameter int MAX_SCENES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [15:0]                    cfg_data,
    input  wire logic                           symbol_valid,
    output logic                                symbol_stall,
    input  wire logic [7:0]                     symbol,
    input  wire logic                           song_end,
    output logic                                event_valid,
    input  wire logic                           event_stall,
    output logic [1:0]                          event_kind,
    output logic [nsts_pkg::DUR_W-1:0]          duration_ms,
    output logic [nsts_pkg::DUR_W-1:0]          buzz_ms,
    output logic [6:0]                          intensity,
    output logic                                scene_valid,
    output logic [nsts_pkg::SCENE_W-1:0]        scene_index,
    output logic                                lights_off_at_half,
    output logic                                last_result
);

    localparam int SCENE_CAP = (MAX_SCENES < 16) ? MAX_SCENES : 16;
    localparam logic [nsts_pkg::SIZE_W-1:0] SCENE_CAP_V = nsts_pkg::SIZE_W'(SCENE_CAP);

    logic [15:0]                    tempo_reg;
    logic [nsts_pkg::GAP_W-1:0]     gap_reg;
    logic [nsts_pkg::SIZE_W-1:0]    show_reg;
    logic [nsts_pkg::SIZE_W-1:0]    show_eff;
    logic                           busy;
    logic                           accept;
    logic                           job_start;
    nsts_pkg::job_t                 job;
    nsts_pkg::result_t              result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= nsts_pkg::TEMPO_RESET;
            gap_reg   <= nsts_pkg::GAP_RESET;
            show_reg  <= nsts_pkg::SHOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nsts_pkg::CFG_TEMPO: tempo_reg <= cfg_data;
                nsts_pkg::CFG_GAP:   gap_reg   <= cfg_data[nsts_pkg::GAP_W-1:0];
                nsts_pkg::CFG_SHOW:  show_reg  <= cfg_data[nsts_pkg::SIZE_W-1:0];
                default:             tempo_reg <= tempo_reg;
            endcase
        end
    end

    assign show_eff     = (show_reg > SCENE_CAP_V) ? SCENE_CAP_V : show_reg;
    assign symbol_stall = busy;
    assign accept       = symbol_valid && !busy;

    nsts_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .symbol    (symbol),
        .song_end  (song_end),
        .job       (job),
        .job_start (job_start)
    );

    nsts_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_start (job_start),
        .job       (job),
        .tempo     (tempo_reg),
        .gap       (gap_reg),
        .show_size (show_eff),
        .busy      (busy),
        .out_valid (event_valid),
        .out_stall (event_stall),
        .result    (result)
    );

    assign event_kind         = result.kind;
    assign duration_ms        = result.duration;
    assign buzz_ms            = result.buzz;
    assign intensity          = result.intensity;
    assign scene_valid        = result.scene_valid;
    assign scene_index        = result.scene_index;
    assign lights_off_at_half = result.lights_half;
    assign last_result        = result.last;

endmodule

`default_nettype wire

// ===== hdl/nsts_checker.sv =====
// ----------------------------------------------------------------------------
// Note string tone sequencer checker
// Port-level properties of the symbol and event streams, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nsts_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        symbol_valid,
    input wire logic                        symbol_stall,
    input wire logic                        song_end,
    input wire logic                        event_valid,
    input wire logic                        event_stall,
    input wire logic [1:0]                  event_kind,
    input wire logic [nsts_pkg::DUR_W-1:0]  duration_ms,
    input wire logic [nsts_pkg::DUR_W-1:0]  buzz_ms,
    input wire logic [6:0]                  intensity,
    input wire logic                        scene_valid,
    input wire logic                        last_result
);

    a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid)
        else $error("Stalled event was dropped.");

    a_end_event: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == nsts_pkg::EVENT_END) |->
        last_result && (intensity == 7'd0) && !scene_valid && (buzz_ms == '0)
        && (duration_ms == '0))
        else $error("Song end event carries note data.");

    a_rest_silent: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == nsts_pkg::EVENT_REST) |->
        (buzz_ms == '0) && (intensity == 7'd0) && !scene_valid)
        else $error("Rest event sounds the buzzer.");

    a_note_strength: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == nsts_pkg::EVENT_NOTE) |->
        (intensity == nsts_pkg::INTENSITY_ACCENT) || (intensity == nsts_pkg::INTENSITY_NORMAL))
        else $error("Sounded note has an unexpected intensity.");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_valid && !symbol_stall && song_end |=> symbol_stall)
        else $error("Song end transfer did not start the end sequence.");

endmodule

bind note_string_tone_sequencer_top nsts_checker u_nsts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .song_end     (song_end),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .duration_ms  (duration_ms),
    .buzz_ms      (buzz_ms),
    .intensity    (intensity),
    .scene_valid  (scene_valid),
    .last_result  (last_result)
);

`default_nettype wire
